// File: hw/rtl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg - Modbus RTU read framer/checker shared definitions
// Payload types, register indexes, field codes and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mrf_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int REQ_BYTES   = 8;
    localparam int REQ_IDX_W   = $clog2(REQ_BYTES);

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] BYTE_MASK = 16'h00FF;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_CODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_ADDRESS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_SIZE_BYTES  = 3'd4;

    // Reset values of the configuration registers
    localparam logic        RST_PROTOCOL_MODE    = 1'b0;
    localparam logic [7:0]  RST_DEVICE_ADDRESS   = 8'd1;
    localparam logic [7:0]  RST_FUNCTION_CODE    = 8'd3;
    localparam logic [15:0] RST_REGISTER_ADDRESS = 16'd0;
    localparam logic [7:0]  RST_DATA_SIZE_BYTES  = 8'd2;

    localparam logic MODE_RTU    = 1'b0;
    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_ANSWER  = 1'b1;
    localparam logic KIND_REQ    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Request byte positions
    localparam logic [REQ_IDX_W-1:0] REQ_LAST_DATA = 3'd5;
    localparam logic [REQ_IDX_W-1:0] REQ_CRC_LO    = 3'd6;
    localparam logic [REQ_IDX_W-1:0] REQ_CRC_HI    = 3'd7;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last_of_run;
        logic       crc_ok;
        logic       too_short;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  device_address;
        logic [7:0]  function_code;
        logic [15:0] register_address;
        logic [7:0]  data_size_bytes;
    } t_req_cfg;

    typedef struct packed {
        logic       emit;
        logic       crc_ok;
        logic       too_short;
    } t_verdict;

    typedef struct packed {
        logic       busy;
        logic [7:0] tx_byte;
        logic       last;
    } t_req_out;

    // Reflected CRC-16 update over one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ (BYTE_MASK & {8'h00, b});
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/modbus_rtu_read_framer_checker.sv
// ----------------------------------------------------------------------------
// modbus_rtu_read_framer_checker - Modbus RTU read framer and answer checker
// Answer bytes: one per cycle unless stalled; the verdict goes from the input
// register to the output register. Request: eight output transfers, one per
// cycle, gated by the output port; the input holds off until the last one leaves.
// Synchronous active-low reset clears handshakes and checker state and
// returns the config registers to their defaults.
// ----------------------------------------------------------------------------
module modbus_rtu_read_framer_checker
    import mrf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_mode;
    t_req_cfg  r_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic      out_free;
    logic      consume;
    logic      req_start;
    logic      req_adv;
    logic      ans_step;
    t_verdict  verdict;
    t_req_out  req;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode                 <= RST_PROTOCOL_MODE;
            r_cfg.device_address   <= RST_DEVICE_ADDRESS;
            r_cfg.function_code    <= RST_FUNCTION_CODE;
            r_cfg.register_address <= RST_REGISTER_ADDRESS;
            r_cfg.data_size_bytes  <= RST_DATA_SIZE_BYTES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PROTOCOL_MODE:    r_mode                 <= i_cfg_data[0];
                CFG_DEVICE_ADDRESS:   r_cfg.device_address   <= i_cfg_data[7:0];
                CFG_FUNCTION_CODE:    r_cfg.function_code    <= i_cfg_data[7:0];
                CFG_REGISTER_ADDRESS: r_cfg.register_address <= i_cfg_data;
                CFG_DATA_SIZE_BYTES:  r_cfg.data_size_bytes  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input stage; a running request holds it until its last byte leaves
    assign out_free   = !r_out_valid || !i_out_stall;
    assign consume    = r_in_valid && !req.busy && out_free;
    assign o_in_stall = r_in_valid && !consume;
    assign req_start  = consume && (r_in.action == ACT_REQUEST) && (r_mode == MODE_RTU);
    assign req_adv    = req.busy && out_free;
    assign ans_step   = consume && (r_in.action == ACT_ANSWER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    mrf_answer_check u_answer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (ans_step),
        .i_mode      (r_mode),
        .i_rx_byte   (r_in.rx_byte),
        .i_frame_end (r_in.frame_end),
        .o_verdict   (verdict)
    );

    mrf_req_serial u_req (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (req_start),
        .i_adv   (req_adv),
        .i_cfg   (r_cfg),
        .o_req   (req)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (req_start || req_adv) begin
            n_out_valid       = 1'b1;
            n_out.kind        = KIND_REQ;
            n_out.tx_byte     = req.tx_byte;
            n_out.last_of_run = req.last;
            n_out.crc_ok      = 1'b0;
            n_out.too_short   = 1'b0;
        end else if (ans_step && verdict.emit) begin
            n_out_valid       = 1'b1;
            n_out.kind        = KIND_VERDICT;
            n_out.tx_byte     = 8'h00;
            n_out.last_of_run = 1'b1;
            n_out.crc_ok      = verdict.crc_ok;
            n_out.too_short   = verdict.too_short;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: hw/rtl/mrf_answer_check.sv
// ----------------------------------------------------------------------------
// mrf_answer_check - answer frame CRC checker
// Runs the CRC over answer bytes through a two-byte delay line and forms the
// verdict on the byte that ends the frame.
// ----------------------------------------------------------------------------
module mrf_answer_check
    import mrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_mode,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_end,
    output t_verdict   o_verdict
);

    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_held0, n_held0;
    logic [7:0]  r_held1, n_held1;
    logic [1:0]  r_seen, n_seen;
    logic [15:0] crc_upd;
    logic [1:0]  seen_inc;

    always_comb begin
        crc_upd  = (r_seen >= 2'd2) ? crc_byte(r_crc, r_held0) : r_crc;
        seen_inc = (r_seen == 2'd3) ? r_seen : r_seen + 2'd1;

        o_verdict.emit      = (i_mode == MODE_RTU) && i_frame_end;
        o_verdict.too_short = (seen_inc <= 2'd2);
        o_verdict.crc_ok    = !o_verdict.too_short && ({i_rx_byte, r_held1} == crc_upd);

        n_crc   = r_crc;
        n_held0 = r_held0;
        n_held1 = r_held1;
        n_seen  = r_seen;
        if (i_step) begin
            if (i_mode == MODE_RTU) begin
                n_crc   = crc_upd;
                n_held0 = r_held1;
                n_held1 = i_rx_byte;
                n_seen  = seen_inc;
            end
            // frame end always returns the checker to its idle state
            if (i_frame_end) begin
                n_crc   = CRC_INIT;
                n_held0 = 8'h00;
                n_held1 = 8'h00;
                n_seen  = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_INIT;
            r_held0 <= 8'h00;
            r_held1 <= 8'h00;
            r_seen  <= 2'd0;
        end else begin
            r_crc   <= n_crc;
            r_held0 <= n_held0;
            r_held1 <= n_held1;
            r_seen  <= n_seen;
        end
    end

endmodule

// File: hw/rtl/mrf_req_serial.sv
// ----------------------------------------------------------------------------
// mrf_req_serial - read request serialiser
// Emits the eight request bytes one per transfer, folding each header byte
// into the CRC as it goes out.
// ----------------------------------------------------------------------------
module mrf_req_serial
    import mrf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_adv,
    input  t_req_cfg i_cfg,
    output t_req_out o_req
);

    logic [REQ_IDX_W-1:0] r_idx, n_idx;
    logic [15:0]          r_crc, n_crc;
    logic                 r_busy, n_busy;
    logic [REQ_IDX_W-1:0] idx;
    logic [15:0]          crc;
    logic [7:0]           tx;

    always_comb begin
        // a start uses the first byte position straight away
        idx = i_start ? '0 : r_idx;
        crc = i_start ? CRC_INIT : r_crc;

        case (idx)
            3'd0:       tx = i_cfg.device_address;
            3'd1:       tx = i_cfg.function_code;
            3'd2:       tx = i_cfg.register_address[15:8];
            3'd3:       tx = i_cfg.register_address[7:0];
            3'd4:       tx = 8'h00;
            3'd5:       tx = {1'b0, i_cfg.data_size_bytes[7:1]};
            REQ_CRC_LO: tx = crc[7:0];
            REQ_CRC_HI: tx = crc[15:8];
            default:    tx = 8'h00;
        endcase

        o_req.busy    = r_busy;
        o_req.tx_byte = tx;
        o_req.last    = (idx == REQ_CRC_HI);

        n_idx  = r_idx;
        n_crc  = r_crc;
        n_busy = r_busy;
        if (i_start || i_adv) begin
            n_idx  = idx + 1'b1;
            n_crc  = (idx <= REQ_LAST_DATA) ? crc_byte(crc, tx) : crc;
            n_busy = (idx != REQ_CRC_HI);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

endmodule

// File: hw/rtl/mrf_checker.sv
// ----------------------------------------------------------------------------
// mrf_checker - port-level checks for the Modbus RTU framer/checker
// Checks stall holding, request run continuity, verdict form, request flags and reset.
// ----------------------------------------------------------------------------
module mrf_checker
    import mrf_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_item
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // A request run continues without gaps after each transfer
    a_req_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && (o_out_item.kind == KIND_REQ)
            && !o_out_item.last_of_run
        |=> o_out_valid && (o_out_item.kind == KIND_REQ))
        else $error("request run broken");

    a_verdict_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind == KIND_VERDICT)
        |-> o_out_item.last_of_run && (o_out_item.tx_byte == 8'h00)
            && !(o_out_item.crc_ok && o_out_item.too_short))
        else $error("malformed verdict");

    a_req_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind == KIND_REQ)
        |-> !o_out_item.crc_ok && !o_out_item.too_short)
        else $error("request byte carries verdict flags");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind modbus_rtu_read_framer_checker mrf_checker u_mrf_checker (.*);

// File: tb/tb_modbus_rtu_read_framer_checker.sv
// ----------------------------------------------------------------------------
// tb_modbus_rtu_read_framer_checker - self-checking bench for the RTU framer
// Builds read requests and answer frames (good, corrupted, short, interleaved,
// silent mode), predicts every request byte and verdict in the bench, and
// compares each output transfer in order under random sender gaps and stalls.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_read_framer_checker;
    import mrf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 280;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 5000;

    localparam logic MODE_OTHER = ~MODE_RTU;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Bench copy of the registers
    logic        cur_mode;
    logic [7:0]  cur_node;
    logic [7:0]  cur_func;
    logic [15:0] cur_reg;
    logic [7:0]  cur_size;

    // Bench copy of the answer checker
    logic [15:0] ans_crc;
    logic [7:0]  held [2];
    logic [1:0]  seen_cnt;

    t_out_item due_frame_out [$];
    int        err_count  = 0;
    int        items_done = 0;
    int        burst_left = 0;

    modbus_rtu_read_framer_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc16_modbus(input logic [15:0] acc,
                                                 input logic [7:0] data);
        logic [15:0] r;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ data[k]) r = (r >> 1) ^ CRC_POLY;
            else r = r >> 1;
        end
        return r;
    endfunction

    function automatic void clear_answer_state();
        ans_crc  = CRC_INIT;
        held[0]  = 8'h00;
        held[1]  = 8'h00;
        seen_cnt = 2'd0;
    endfunction

    // Append one expected result to the tail of the queue
    function automatic void add_due(input logic kind, input logic [7:0] tx,
                                    input logic last, input logic ok, input logic shortf);
        t_out_item item;
        item.kind        = kind;
        item.tx_byte     = tx;
        item.last_of_run = last;
        item.crc_ok      = ok;
        item.too_short   = shortf;
        due_frame_out.insert(due_frame_out.size(), item);
    endfunction

    // Work out the request bytes or the verdict caused by one accepted item
    function automatic void frame_or_check(input t_in_item it);
        logic [7:0]  hdr [6];
        logic [15:0] acc;
        logic [15:0] words;
        logic [15:0] got;
        if (it.action == ACT_REQUEST) begin
            if (cur_mode != MODE_RTU) return;
            words  = {8'h00, cur_size} >> 1;
            hdr[0] = cur_node;
            hdr[1] = cur_func;
            hdr[2] = cur_reg[15:8];
            hdr[3] = cur_reg[7:0];
            hdr[4] = words[15:8];
            hdr[5] = words[7:0];
            acc = CRC_INIT;
            for (int i = 0; i < 6; i++) begin
                acc = crc16_modbus(acc, hdr[i]);
                add_due(KIND_REQ, hdr[i], 1'b0, 1'b0, 1'b0);
            end
            add_due(KIND_REQ, acc[7:0], 1'b0, 1'b0, 1'b0);
            add_due(KIND_REQ, acc[15:8], 1'b1, 1'b0, 1'b0);
            return;
        end
        if (cur_mode != MODE_RTU) begin
            if (it.frame_end) clear_answer_state();
            return;
        end
        // The last two bytes wait in the delay line; only older ones reach the CRC
        if (seen_cnt >= 2'd2) ans_crc = crc16_modbus(ans_crc, held[0]);
        held[0] = held[1];
        held[1] = it.rx_byte;
        if (seen_cnt != 2'd3) seen_cnt++;
        if (!it.frame_end) return;
        if (seen_cnt <= 2'd2) begin
            add_due(KIND_VERDICT, 8'h00, 1'b1, 1'b0, 1'b1);
        end else begin
            got = {held[1], held[0]};
            add_due(KIND_VERDICT, 8'h00, 1'b1, (got == ans_crc), 1'b0);
        end
        clear_answer_state();
    endfunction

    function automatic t_in_item answer_byte(input logic [7:0] b, input logic last);
        t_in_item it;
        it.action    = ACT_ANSWER;
        it.rx_byte   = b;
        it.frame_end = last;
        return it;
    endfunction

    // Request with junk in the fields that a request ignores
    function automatic t_in_item request_item();
        t_in_item it;
        it.action    = ACT_REQUEST;
        it.rx_byte   = 8'($urandom_range(0, 255));
        it.frame_end = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    // Offer one item and hold it until the transfer
    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_done++;
        frame_or_check(it);
    endtask

    // Drop the input and wait until every result is in and the pipeline is quiet
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (due_frame_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves valid high so that back-to-back writes need no gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_PROTOCOL_MODE:    cur_mode = data[0];
            CFG_DEVICE_ADDRESS:   cur_node = data[7:0];
            CFG_FUNCTION_CODE:    cur_func = data[7:0];
            CFG_REGISTER_ADDRESS: cur_reg  = data;
            CFG_DATA_SIZE_BYTES:  cur_size = data[7:0];
            default: ;
        endcase
    endtask

    // Unused upper bits carry junk; the block must drop them
    task automatic apply_cfg(input logic mode, input logic [7:0] node, input logic [7:0] func,
                             input logic [15:0] regaddr, input logic [7:0] size);
        wait_idle();
        write_reg(CFG_PROTOCOL_MODE, {15'($urandom_range(0, 32767)), mode});
        write_reg(CFG_DEVICE_ADDRESS, {8'($urandom_range(0, 255)), node});
        write_reg(CFG_FUNCTION_CODE, {8'($urandom_range(0, 255)), func});
        write_reg(CFG_REGISTER_ADDRESS, regaddr);
        write_reg(CFG_DATA_SIZE_BYTES, {8'($urandom_range(0, 255)), size});
        i_cfg_valid <= 1'b0;
    endtask

    // Send a frame, marking its last byte; a request goes in before byte cut (none if -1)
    task automatic send_bytes(input logic [7:0] bytes [$], input int cut);
        foreach (bytes[i]) begin
            if (i == cut) send_item(request_item());
            send_item(answer_byte(bytes[i], i == bytes.size() - 1));
        end
    endtask

    // Random body with its CRC appended, optionally with one bit flipped
    task automatic send_answer(input int body_len, input bit flip, input bit mid_request);
        logic [7:0]  bytes [$];
        logic [15:0] acc;
        int          pos;
        acc = CRC_INIT;
        for (int i = 0; i < body_len; i++) begin
            bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            acc = crc16_modbus(acc, bytes[i]);
        end
        bytes.insert(bytes.size(), acc[7:0]);
        bytes.insert(bytes.size(), acc[15:8]);
        if (flip) begin
            pos = $urandom_range(0, bytes.size() - 1);
            bytes[pos] = bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        send_bytes(bytes, mid_request ? $urandom_range(0, bytes.size() - 1) : -1);
    endtask

    task automatic test_default_request();
        send_item(request_item());
    endtask

    task automatic test_register_extremes();
        apply_cfg(MODE_RTU, 8'h00, 8'h00, 16'h0000, 8'h00);
        send_item(request_item());
        apply_cfg(MODE_RTU, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(request_item());
        // odd size of one byte: word count drops to zero
        apply_cfg(MODE_RTU, 8'h11, 8'h04, 16'h006B, 8'h01);
        send_item(request_item());
    endtask

    task automatic test_unknown_index();
        wait_idle();
        write_reg(CFG_UNUSED_FIRST, 16'hFFFF);
        write_reg(CFG_UNUSED_LAST, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        send_item(request_item());
    endtask

    task automatic test_answer_frames();
        logic [7:0]  bytes [$];
        logic [15:0] acc;
        bytes = {8'h01, 8'h03, 8'h00};
        acc = crc16_modbus(crc16_modbus(crc16_modbus(CRC_INIT, 8'h01), 8'h03), 8'h00);
        bytes.insert(bytes.size(), acc[7:0]);
        bytes.insert(bytes.size(), acc[15:8]);
        send_bytes(bytes, -1);
        send_answer(1, 1'b1, 1'b0);
        // one byte and two bytes: too short, even where the bytes look like a CRC
        bytes = {8'h00};
        send_bytes(bytes, -1);
        bytes = {8'hFF, 8'hFF};
        send_bytes(bytes, -1);
        send_answer(1, 1'b0, 1'b0);
    endtask

    task automatic test_interleave();
        send_answer(1, 1'b0, 1'b1);
        send_answer(2, 1'b0, 1'b1);
    endtask

    task automatic test_silent_mode();
        logic [15:0] acc;
        apply_cfg(MODE_OTHER, 8'h22, 8'h03, 16'h1234, 8'h04);
        send_item(request_item());
        send_item(answer_byte(8'h5A, 1'b0));
        send_item(answer_byte(8'hA5, 1'b1));
        // open a frame, pass a silent byte through it, then finish it
        acc = crc16_modbus(crc16_modbus(CRC_INIT, 8'hAA), 8'h55);
        apply_cfg(MODE_RTU, 8'h22, 8'h03, 16'h1234, 8'h04);
        send_item(answer_byte(8'hAA, 1'b0));
        apply_cfg(MODE_OTHER, 8'h22, 8'h03, 16'h1234, 8'h04);
        send_item(answer_byte(8'h3C, 1'b0));
        apply_cfg(MODE_RTU, 8'h22, 8'h03, 16'h1234, 8'h04);
        send_item(answer_byte(8'h55, 1'b0));
        send_item(answer_byte(acc[7:0], 1'b0));
        send_item(answer_byte(acc[15:8], 1'b1));
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int phase;
        int pick;
        int len;
        stop_at = items_done + RANDOM_ITEMS;
        phase = 0;
        while (items_done < stop_at) begin
            case (phase % 5)
                1: apply_cfg(MODE_RTU, 8'h00, 8'h00, 16'h0000, 8'h00);
                2: apply_cfg(MODE_RTU, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
                3: apply_cfg(MODE_OTHER, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
                default: apply_cfg(MODE_RTU, 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                                   8'($urandom_range(0, 255)));
            endcase
            repeat ($urandom_range(8, 20)) begin
                pick = $urandom_range(0, 99);
                len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
                if (pick < 60) begin
                    send_answer(len, 1'b0, $urandom_range(0, 7) == 0);
                end else if (pick < 72) begin
                    send_answer(len, 1'b1, $urandom_range(0, 7) == 0);
                end else if (pick < 84) begin
                    send_item(request_item());
                end else if (pick < 92) begin
                    repeat ($urandom_range(0, 1)) send_item(answer_byte(8'($urandom), 1'b0));
                    send_item(answer_byte(8'($urandom), 1'b1));
                end else begin
                    repeat ($urandom_range(1, 4)) send_item(10'($urandom_range(0, 1023)));
                end
            end
            phase++;
        end
    endtask

    // Receiver: stall rate changes every so often, with stretches of none
    initial begin
        int span;
        int pct;
        span = 0;
        pct  = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                span = $urandom_range(40, 160);
                case ($urandom_range(0, 4))
                    0, 1:    pct = 0;
                    2:       pct = 30;
                    3:       pct = 60;
                    default: pct = 90;
                endcase
            end
            span--;
            i_out_stall <= ($urandom_range(0, 99) < pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_frame_out.size() == 0) begin
                report_mismatch("result with nothing expected", 16'(o_out_item), 16'h0000);
            end else begin
                want = due_frame_out[0];
                due_frame_out.delete(0);
                if (o_out_item.kind !== want.kind)
                    report_mismatch("kind", 16'(o_out_item.kind), 16'(want.kind));
                if (o_out_item.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", 16'(o_out_item.tx_byte), 16'(want.tx_byte));
                if (o_out_item.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", 16'(o_out_item.last_of_run),
                                    16'(want.last_of_run));
                if (o_out_item.crc_ok !== want.crc_ok)
                    report_mismatch("crc_ok", 16'(o_out_item.crc_ok), 16'(want.crc_ok));
                if (o_out_item.too_short !== want.too_short)
                    report_mismatch("too_short", 16'(o_out_item.too_short), 16'(want.too_short));
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge i_clk) begin
        int quiet_cycles;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, due_frame_out.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_PROTOCOL_MODE;
        i_cfg_data  <= '0;
        cur_mode = RST_PROTOCOL_MODE;
        cur_node = RST_DEVICE_ADDRESS;
        cur_func = RST_FUNCTION_CODE;
        cur_reg  = RST_REGISTER_ADDRESS;
        cur_size = RST_DATA_SIZE_BYTES;
        clear_answer_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_request();
        test_register_extremes();
        test_unknown_index();
        test_answer_frames();
        test_interleave();
        test_silent_mode();
        test_random_traffic();

        wait_idle();
        if (err_count == 0 && due_frame_out.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: modbus_rtu_read_framer_checker.f
hw/rtl/mrf_pkg.sv
hw/rtl/mrf_answer_check.sv
hw/rtl/mrf_req_serial.sv
hw/rtl/modbus_rtu_read_framer_checker.sv
hw/rtl/mrf_checker.sv
tb/tb_modbus_rtu_read_framer_checker.sv
